// File: rtl/pwfb_pkg.sv
// ============================================================================
// pwfb_pkg: shared types and constants for the PID controller
// Register map codes, feedforward modes, configuration record and the
// flags that travel with each item through the datapath.
// ============================================================================
package pwfb_pkg;

    // Default sample width and gain format.
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Fixed field widths.
    localparam int GAIN_W  = 16;   // unsigned Q8.8 gains
    localparam int ILIM_W  = 31;   // integral limit
    localparam int SUM_W   = 32;   // stored error sum, holds +/- integral limit
    localparam int MODE_W  = 2;

    // Configuration port.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Input command codes.
    localparam logic CMD_RUN   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Feedforward modes; the unused code behaves as no feedforward.
    typedef enum logic [MODE_W-1:0] {
        FF_NONE   = 2'd0,
        FF_FIRST  = 2'd1,
        FF_SECOND = 2'd2
    } t_ff_mode;

    // Register indexes (byte address is four times the index).
    typedef enum logic [REG_IDX_W-1:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_INTEG_GAIN     = 3'd1,
        REG_DERIV_GAIN     = 3'd2,
        REG_FF_GAIN        = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_OUTPUT_LIMIT   = 3'd5,
        REG_FF_MODE        = 3'd6
    } t_reg_idx;

    // Configuration fields of fixed width.
    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [GAIN_W-1:0] ff_gain;
        logic [ILIM_W-1:0] integral_limit;
        t_ff_mode          ff_mode;
    } t_cfg;

    // Per-item control flags carried down the pipeline.
    typedef struct packed {
        logic clear;    // item was a clear command
        logic iclamp;   // integral hit its limit
    } t_step_flags;

endpackage

// File: rtl/pwfb_regs.sv
// ============================================================================
// pwfb_regs: configuration register file
// APB-style write and read access to the seven controller registers.
// ============================================================================
module pwfb_regs #(
    parameter int OLIM_W = pwfb_pkg::SAMPLE_WIDTH_DEF - 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pwfb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pwfb_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [pwfb_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output pwfb_pkg::t_cfg                  o_cfg,
    output logic [OLIM_W-1:0]               o_output_limit
);

    pwfb_pkg::t_cfg        r_cfg;
    logic [OLIM_W-1:0]     r_output_limit;
    pwfb_pkg::t_reg_idx    reg_idx;
    logic                  wr_en;

    assign reg_idx = pwfb_pkg::t_reg_idx'(paddr[pwfb_pkg::CFG_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes; a write to an unmapped index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain      <= '0;
            r_cfg.integ_gain     <= '0;
            r_cfg.deriv_gain     <= '0;
            r_cfg.ff_gain        <= '0;
            r_cfg.integral_limit <= '0;
            r_cfg.ff_mode        <= pwfb_pkg::FF_NONE;
            r_output_limit       <= '1;
        end else if (wr_en) begin
            unique case (reg_idx)
                pwfb_pkg::REG_PROP_GAIN: begin
                    r_cfg.prop_gain <= pwdata[pwfb_pkg::GAIN_W-1:0];
                end
                pwfb_pkg::REG_INTEG_GAIN: begin
                    r_cfg.integ_gain <= pwdata[pwfb_pkg::GAIN_W-1:0];
                end
                pwfb_pkg::REG_DERIV_GAIN: begin
                    r_cfg.deriv_gain <= pwdata[pwfb_pkg::GAIN_W-1:0];
                end
                pwfb_pkg::REG_FF_GAIN: begin
                    r_cfg.ff_gain <= pwdata[pwfb_pkg::GAIN_W-1:0];
                end
                pwfb_pkg::REG_INTEGRAL_LIMIT: begin
                    r_cfg.integral_limit <= pwdata[pwfb_pkg::ILIM_W-1:0];
                end
                pwfb_pkg::REG_OUTPUT_LIMIT: begin
                    r_output_limit <= pwdata[OLIM_W-1:0];
                end
                pwfb_pkg::REG_FF_MODE: begin
                    r_cfg.ff_mode <= pwfb_pkg::t_ff_mode'(pwdata[pwfb_pkg::MODE_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // Read mux.
    always_comb begin
        unique case (reg_idx)
            pwfb_pkg::REG_PROP_GAIN:      prdata = pwfb_pkg::CFG_DATA_W'(r_cfg.prop_gain);
            pwfb_pkg::REG_INTEG_GAIN:     prdata = pwfb_pkg::CFG_DATA_W'(r_cfg.integ_gain);
            pwfb_pkg::REG_DERIV_GAIN:     prdata = pwfb_pkg::CFG_DATA_W'(r_cfg.deriv_gain);
            pwfb_pkg::REG_FF_GAIN:        prdata = pwfb_pkg::CFG_DATA_W'(r_cfg.ff_gain);
            pwfb_pkg::REG_INTEGRAL_LIMIT: prdata = pwfb_pkg::CFG_DATA_W'(r_cfg.integral_limit);
            pwfb_pkg::REG_OUTPUT_LIMIT:   prdata = pwfb_pkg::CFG_DATA_W'(r_output_limit);
            pwfb_pkg::REG_FF_MODE:        prdata = pwfb_pkg::CFG_DATA_W'(r_cfg.ff_mode);
            default:                      prdata = '0;
        endcase
    end

    assign o_cfg          = r_cfg;
    assign o_output_limit = r_output_limit;

endmodule

// File: rtl/pwfb_state.sv
// ============================================================================
// pwfb_state: error, integral and feedforward state update
// Forms the error, its difference, the clamped error sum and the feedforward
// difference for one item, updates the controller state and registers the
// operands for the multiplier stage.
// ============================================================================
module pwfb_state #(
    parameter int SAMPLE_WIDTH = pwfb_pkg::SAMPLE_WIDTH_DEF,
    localparam int ERR_W  = SAMPLE_WIDTH + 1,
    localparam int DIFF_W = SAMPLE_WIDTH + 2,
    localparam int FF_W   = SAMPLE_WIDTH + 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pwfb_pkg::t_cfg                  i_cfg,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_setpoint,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_measured,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_ff_reference,
    output logic                            o_valid,
    input  logic                            i_ready,
    output pwfb_pkg::t_step_flags           o_flags,
    output logic signed [ERR_W-1:0]         o_err,
    output logic signed [pwfb_pkg::SUM_W-1:0] o_sum,
    output logic signed [DIFF_W-1:0]        o_diff,
    output logic signed [FF_W-1:0]          o_ff
);

    localparam int SUM_W = pwfb_pkg::SUM_W;
    localparam int ACC_W = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;

    // Controller state.
    logic signed [ERR_W-1:0]        r_last_error;
    logic signed [SUM_W-1:0]        r_error_sum;
    logic signed [SAMPLE_WIDTH-1:0] r_ff_hist0;
    logic signed [SAMPLE_WIDTH-1:0] r_ff_hist1;

    // Operand register.
    logic                           r_valid;
    pwfb_pkg::t_step_flags          r_flags;
    logic signed [ERR_W-1:0]        r_err;
    logic signed [SUM_W-1:0]        r_sum;
    logic signed [DIFF_W-1:0]       r_diff;
    logic signed [FF_W-1:0]         r_ff;

    logic                           fire;
    logic signed [ERR_W-1:0]        n_err;
    logic signed [DIFF_W-1:0]       n_diff;
    logic signed [ACC_W-1:0]        sum_tmp;
    logic signed [ACC_W-1:0]        lim_pos;
    logic signed [ACC_W-1:0]        lim_neg;
    logic signed [SUM_W-1:0]        n_sum;
    logic                           n_iclamp;
    logic signed [FF_W-1:0]         ref_x;
    logic signed [FF_W-1:0]         hist0_x;
    logic signed [FF_W-1:0]         hist1_x;
    logic signed [FF_W-1:0]         n_ff;

    assign o_ready = !r_valid || i_ready;
    assign fire    = i_valid && o_ready;

    // Error and its first difference.
    assign n_err  = ERR_W'(i_setpoint) - ERR_W'(i_measured);
    assign n_diff = DIFF_W'(n_err) - DIFF_W'(r_last_error);

    // Running error sum with symmetric clamp; equality counts as clamped.
    assign sum_tmp = ACC_W'(r_error_sum) + ACC_W'(n_err);
    assign lim_pos = $signed({{(ACC_W - pwfb_pkg::ILIM_W){1'b0}}, i_cfg.integral_limit});
    assign lim_neg = -lim_pos;

    always_comb begin
        if (sum_tmp <= lim_neg) begin
            n_sum    = lim_neg[SUM_W-1:0];
            n_iclamp = 1'b1;
        end else if (sum_tmp >= lim_pos) begin
            n_sum    = lim_pos[SUM_W-1:0];
            n_iclamp = 1'b1;
        end else begin
            n_sum    = sum_tmp[SUM_W-1:0];
            n_iclamp = 1'b0;
        end
    end

    // Feedforward difference, with the new sample as the newest point.
    assign ref_x   = FF_W'(i_ff_reference);
    assign hist0_x = FF_W'(r_ff_hist0);
    assign hist1_x = FF_W'(r_ff_hist1);

    always_comb begin
        unique case (i_cfg.ff_mode)
            pwfb_pkg::FF_FIRST:  n_ff = ref_x - hist0_x;
            pwfb_pkg::FF_SECOND: n_ff = ref_x - (hist0_x <<< 1) + hist1_x;
            default:             n_ff = '0;
        endcase
    end

    // State update and valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_last_error <= '0;
            r_error_sum  <= '0;
            r_ff_hist0   <= '0;
            r_ff_hist1   <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (fire) begin
                if (i_cmd == pwfb_pkg::CMD_CLEAR) begin
                    r_last_error <= '0;
                    r_error_sum  <= '0;
                    r_ff_hist0   <= '0;
                    r_ff_hist1   <= '0;
                end else begin
                    r_last_error <= n_err;
                    r_error_sum  <= n_sum;
                    r_ff_hist0   <= i_ff_reference;
                    r_ff_hist1   <= r_ff_hist0;
                end
            end
        end
    end

    // Operands for the multiplier stage; a clear item carries zeros.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            if (i_cmd == pwfb_pkg::CMD_CLEAR) begin
                r_flags.clear  <= 1'b1;
                r_flags.iclamp <= 1'b0;
                r_err          <= '0;
                r_sum          <= '0;
                r_diff         <= '0;
                r_ff           <= '0;
            end else begin
                r_flags.clear  <= 1'b0;
                r_flags.iclamp <= n_iclamp;
                r_err          <= n_err;
                r_sum          <= n_sum;
                r_diff         <= n_diff;
                r_ff           <= n_ff;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_err   = r_err;
    assign o_sum   = r_sum;
    assign o_diff  = r_diff;
    assign o_ff    = r_ff;

endmodule

// File: rtl/pwfb_mult.sv
// ============================================================================
// pwfb_mult: gain multipliers
// Four parallel gain-times-operand products, registered.
// ============================================================================
module pwfb_mult #(
    parameter int SAMPLE_WIDTH = pwfb_pkg::SAMPLE_WIDTH_DEF,
    localparam int ERR_W  = SAMPLE_WIDTH + 1,
    localparam int DIFF_W = SAMPLE_WIDTH + 2,
    localparam int FF_W   = SAMPLE_WIDTH + 3,
    localparam int OPW    = (pwfb_pkg::SUM_W > FF_W) ? pwfb_pkg::SUM_W : FF_W,
    localparam int PW     = pwfb_pkg::GAIN_W + 1 + OPW
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pwfb_pkg::t_cfg                    i_cfg,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  pwfb_pkg::t_step_flags             i_flags,
    input  logic signed [ERR_W-1:0]           i_err,
    input  logic signed [pwfb_pkg::SUM_W-1:0] i_sum,
    input  logic signed [DIFF_W-1:0]          i_diff,
    input  logic signed [FF_W-1:0]            i_ff,
    output logic                              o_valid,
    input  logic                              i_ready,
    output pwfb_pkg::t_step_flags             o_flags,
    output logic signed [PW-1:0]              o_p_prop,
    output logic signed [PW-1:0]              o_p_integ,
    output logic signed [PW-1:0]              o_p_deriv,
    output logic signed [PW-1:0]              o_p_ff
);

    localparam int GW = pwfb_pkg::GAIN_W + 1;

    logic                  r_valid;
    pwfb_pkg::t_step_flags r_flags;
    logic signed [PW-1:0]  r_p_prop;
    logic signed [PW-1:0]  r_p_integ;
    logic signed [PW-1:0]  r_p_deriv;
    logic signed [PW-1:0]  r_p_ff;

    logic signed [GW-1:0]  g_prop;
    logic signed [GW-1:0]  g_integ;
    logic signed [GW-1:0]  g_deriv;
    logic signed [GW-1:0]  g_ff;
    logic signed [PW-1:0]  n_p_prop;
    logic signed [PW-1:0]  n_p_integ;
    logic signed [PW-1:0]  n_p_deriv;
    logic signed [PW-1:0]  n_p_ff;
    logic                  fire;

    assign o_ready = !r_valid || i_ready;
    assign fire    = i_valid && o_ready;

    // Unsigned gains widened by a zero sign bit.
    assign g_prop  = $signed({1'b0, i_cfg.prop_gain});
    assign g_integ = $signed({1'b0, i_cfg.integ_gain});
    assign g_deriv = $signed({1'b0, i_cfg.deriv_gain});
    assign g_ff    = $signed({1'b0, i_cfg.ff_gain});

    // Products, exact at full width.
    assign n_p_prop  = PW'(g_prop)  * PW'(i_err);
    assign n_p_integ = PW'(g_integ) * PW'(i_sum);
    assign n_p_deriv = PW'(g_deriv) * PW'(i_diff);
    assign n_p_ff    = PW'(g_ff)    * PW'(i_ff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_flags   <= i_flags;
            r_p_prop  <= n_p_prop;
            r_p_integ <= n_p_integ;
            r_p_deriv <= n_p_deriv;
            r_p_ff    <= n_p_ff;
        end
    end

    assign o_valid   = r_valid;
    assign o_flags   = r_flags;
    assign o_p_prop  = r_p_prop;
    assign o_p_integ = r_p_integ;
    assign o_p_deriv = r_p_deriv;
    assign o_p_ff    = r_p_ff;

endmodule

// File: rtl/pwfb_out.sv
// ============================================================================
// pwfb_out: output summation and saturation
// Sums the four products, drops the gain fraction with floor rounding,
// saturates to the output limit and holds the result in the output register.
// ============================================================================
module pwfb_out #(
    parameter int SAMPLE_WIDTH   = pwfb_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = pwfb_pkg::GAIN_FRAC_BITS_DEF,
    parameter int PW             = 49,
    localparam int OLIM_W        = SAMPLE_WIDTH - 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [OLIM_W-1:0]               i_output_limit,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  pwfb_pkg::t_step_flags           i_flags,
    input  logic signed [PW-1:0]            i_p_prop,
    input  logic signed [PW-1:0]            i_p_integ,
    input  logic signed [PW-1:0]            i_p_deriv,
    input  logic signed [PW-1:0]            i_p_ff,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [SAMPLE_WIDTH-1:0]  o_drive,
    output logic                            o_integral_clamped,
    output logic                            o_output_saturated
);

    localparam int TW = PW + 2;

    logic                           r_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_drive;
    logic                           r_iclamp;
    logic                           r_osat;

    logic signed [TW-1:0]           total;
    logic signed [TW-1:0]           scaled;
    logic signed [TW-1:0]           olim_pos;
    logic signed [TW-1:0]           olim_neg;
    logic signed [SAMPLE_WIDTH-1:0] n_drive;
    logic                           n_osat;
    logic                           fire;

    assign o_ready = !r_valid || i_ready;
    assign fire    = i_valid && o_ready;

    // Exact sum, then arithmetic shift (rounds toward minus infinity).
    assign total  = TW'(i_p_prop) + TW'(i_p_integ) + TW'(i_p_deriv) + TW'(i_p_ff);
    assign scaled = total >>> GAIN_FRAC_BITS;

    assign olim_pos = $signed({{(TW - OLIM_W){1'b0}}, i_output_limit});
    assign olim_neg = -olim_pos;

    // Saturation; a value equal to the limit counts as saturated.
    // A clear item bypasses it and gives zero with no flags.
    always_comb begin
        if (i_flags.clear) begin
            n_drive = '0;
            n_osat  = 1'b0;
        end else if (scaled <= olim_neg) begin
            n_drive = olim_neg[SAMPLE_WIDTH-1:0];
            n_osat  = 1'b1;
        end else if (scaled >= olim_pos) begin
            n_drive = olim_pos[SAMPLE_WIDTH-1:0];
            n_osat  = 1'b1;
        end else begin
            n_drive = scaled[SAMPLE_WIDTH-1:0];
            n_osat  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_drive  <= n_drive;
            r_iclamp <= i_flags.iclamp;
            r_osat   <= n_osat;
        end
    end

    assign o_valid            = r_valid;
    assign o_drive            = r_drive;
    assign o_integral_clamped = r_iclamp;
    assign o_output_saturated = r_osat;

endmodule

// File: rtl/pid_with_reference_feedforward.sv
// ============================================================================
// pid_with_reference_feedforward: positional PID with anti-windup and
// reference feedforward
// Top level: input register, state update, multipliers, output register
// and the configuration registers.
// ============================================================================
// Each accepted item is one control step (or a clear command) and yields
// exactly one result. The block takes a new item every clock cycle unless
// back-pressure holds the pipeline. A result is valid on the master side
// once its item has passed through the input register, the state-update
// register, the product register and the output register. The integral,
// last error and feedforward history are updated in the state-update stage,
// so consecutive items see each other's state with no gap. Each stage holds
// its item while the one after it is full, so back-pressure on the master
// side fills the pipeline before the slave side stalls. Configuration is
// meant to change only while no item is in flight.
module pid_with_reference_feedforward #(
    parameter int SAMPLE_WIDTH   = pwfb_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = pwfb_pkg::GAIN_FRAC_BITS_DEF,
    localparam int IN_DW  = ((3 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: setpoint, measured, ff_reference (from the lowest bit up)
    input  logic [IN_DW-1:0]                s_axis_tdata,
    // tuser: cmd
    input  logic [0:0]                      s_axis_tuser,
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: drive (from the lowest bit up)
    output logic [OUT_DW-1:0]               m_axis_tdata,
    // tuser: integral_clamped, output_saturated (from the lowest bit up)
    output logic [1:0]                      m_axis_tuser,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pwfb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pwfb_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [pwfb_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int W      = SAMPLE_WIDTH;
    localparam int OLIM_W = W - 1;
    localparam int ERR_W  = W + 1;
    localparam int DIFF_W = W + 2;
    localparam int FF_W   = W + 3;
    localparam int OPW    = (pwfb_pkg::SUM_W > FF_W) ? pwfb_pkg::SUM_W : FF_W;
    localparam int PW     = pwfb_pkg::GAIN_W + 1 + OPW;

    pwfb_pkg::t_cfg                    cfg;
    logic [OLIM_W-1:0]                 output_limit;

    // Input register.
    logic                              r_in_valid;
    logic                              r_in_cmd;
    logic signed [W-1:0]               r_in_setpoint;
    logic signed [W-1:0]               r_in_measured;
    logic signed [W-1:0]               r_in_ff_reference;
    logic                              st_ready;

    // State stage to multiplier stage.
    logic                              st_valid;
    pwfb_pkg::t_step_flags             st_flags;
    logic signed [ERR_W-1:0]           st_err;
    logic signed [pwfb_pkg::SUM_W-1:0] st_sum;
    logic signed [DIFF_W-1:0]          st_diff;
    logic signed [FF_W-1:0]            st_ff;
    logic                              mu_ready;

    // Multiplier stage to output stage.
    logic                              mu_valid;
    pwfb_pkg::t_step_flags             mu_flags;
    logic signed [PW-1:0]              mu_p_prop;
    logic signed [PW-1:0]              mu_p_integ;
    logic signed [PW-1:0]              mu_p_deriv;
    logic signed [PW-1:0]              mu_p_ff;
    logic                              ou_ready;

    logic signed [W-1:0]               drive;

    // Configuration registers.
    pwfb_regs #(
        .OLIM_W (OLIM_W)
    ) u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_cfg          (cfg),
        .o_output_limit (output_limit)
    );

    // Input register: unpack the item fields.
    assign s_axis_tready = !r_in_valid || st_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd          <= s_axis_tuser[0];
            r_in_setpoint     <= s_axis_tdata[W-1:0];
            r_in_measured     <= s_axis_tdata[2*W-1:W];
            r_in_ff_reference <= s_axis_tdata[3*W-1:2*W];
        end
    end

    // Error, integral and feedforward state.
    pwfb_state #(
        .SAMPLE_WIDTH (W)
    ) u_state (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_valid        (r_in_valid),
        .o_ready        (st_ready),
        .i_cmd          (r_in_cmd),
        .i_setpoint     (r_in_setpoint),
        .i_measured     (r_in_measured),
        .i_ff_reference (r_in_ff_reference),
        .o_valid        (st_valid),
        .i_ready        (mu_ready),
        .o_flags        (st_flags),
        .o_err          (st_err),
        .o_sum          (st_sum),
        .o_diff         (st_diff),
        .o_ff           (st_ff)
    );

    // Gain products.
    pwfb_mult #(
        .SAMPLE_WIDTH (W)
    ) u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (st_valid),
        .o_ready   (mu_ready),
        .i_flags   (st_flags),
        .i_err     (st_err),
        .i_sum     (st_sum),
        .i_diff    (st_diff),
        .i_ff      (st_ff),
        .o_valid   (mu_valid),
        .i_ready   (ou_ready),
        .o_flags   (mu_flags),
        .o_p_prop  (mu_p_prop),
        .o_p_integ (mu_p_integ),
        .o_p_deriv (mu_p_deriv),
        .o_p_ff    (mu_p_ff)
    );

    // Sum, scale, saturate and hold the result.
    pwfb_out #(
        .SAMPLE_WIDTH   (W),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .PW             (PW)
    ) u_out (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_output_limit     (output_limit),
        .i_valid            (mu_valid),
        .o_ready            (ou_ready),
        .i_flags            (mu_flags),
        .i_p_prop           (mu_p_prop),
        .i_p_integ          (mu_p_integ),
        .i_p_deriv          (mu_p_deriv),
        .i_p_ff             (mu_p_ff),
        .o_valid            (m_axis_tvalid),
        .i_ready            (m_axis_tready),
        .o_drive            (drive),
        .o_integral_clamped (m_axis_tuser[0]),
        .o_output_saturated (m_axis_tuser[1])
    );

    assign m_axis_tdata = OUT_DW'($unsigned(drive));

endmodule
